/* rtl/pcmf_pkg.sv */
// pcmf_pkg: shared types, constants and helpers of the point cloud cell marking filter
// no dependencies; used by every other file of the block
package pcmf_pkg;

   localparam int CELL_SIZE_MM       = 50;
   localparam int MAX_CELLS_PER_AXIS = 1024;

   localparam int COORD_W  = 24;
   localparam int RANGE_W  = 23;
   localparam int CSR_W    = 24;
   localparam int CSR_IDX_W = 3;
   localparam int CELLS_REG_W = 11;

   // cell counts after saturation and cell coordinates
   localparam int CNT_W = $clog2(MAX_CELLS_PER_AXIS) + 1;
   localparam int IDX_W = $clog2(MAX_CELLS_PER_AXIS);

   // reciprocal for the floor division by the cell size
   localparam int CELL_LOG  = $clog2(CELL_SIZE_MM);
   localparam int DIV_SHIFT = COORD_W + CELL_LOG + 1;
   localparam int RECIP_W   = 26;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(CELL_SIZE_MM) - 64'd1) / 64'(CELL_SIZE_MM));
   localparam int QUOT_W = COORD_W + RECIP_W;

   localparam int MAG_W  = COORD_W + 1;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int DIST_W = SQ_W + 2;
   localparam int RSQ_W  = 2 * RANGE_W;

   localparam int QDEPTH = 8;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = QPTR_W + 1;

   localparam logic signed [COORD_W-1:0] POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] NEG_MAX = {1'b1, {(COORD_W-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_MARKED  = 3'd0,
      ST_LOW     = 3'd1,
      ST_HIGH    = 3'd2,
      ST_FAR     = 3'd3,
      ST_CLOSE   = 3'd4,
      ST_OFFMAP  = 3'd5,
      ST_CLEARED = 3'd6
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MIN_HEIGHT = 3'd0,
      REG_MAX_HEIGHT = 3'd1,
      REG_MAX_RANGE  = 3'd2,
      REG_MIN_RANGE  = 3'd3,
      REG_ORIGIN_X   = 3'd4,
      REG_ORIGIN_Y   = 3'd5,
      REG_CELLS_X    = 3'd6,
      REG_CELLS_Y    = 3'd7
   } csr_reg_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] min_height;
      logic signed [COORD_W-1:0] max_height;
      logic [RANGE_W-1:0]        max_range;
      logic [RANGE_W-1:0]        min_range;
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic [CNT_W-1:0]          cells_x;
      logic [CNT_W-1:0]          cells_y;
   } cfg_type;

   typedef struct packed {
      logic                      kind;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
      logic signed [COORD_W-1:0] sensor_x;
      logic signed [COORD_W-1:0] sensor_y;
      logic signed [COORD_W-1:0] sensor_z;
   } item_type;

   typedef struct packed {
      status_type                status;
      logic [IDX_W-1:0]          col;
      logic [IDX_W-1:0]          row;
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
   } entry_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

   function automatic logic [CNT_W-1:0] sat_cells(input logic [CELLS_REG_W-1:0] n);
      if (32'(n) > MAX_CELLS_PER_AXIS) begin
         return CNT_W'(MAX_CELLS_PER_AXIS);
      end
      return CNT_W'(n);
   endfunction

endpackage

/* rtl/pcmf_if.sv */
// pcmf_if: request and response channel interfaces of the point cloud cell marking filter
// depends on pcmf_pkg for field widths
interface pcmf_req_if;
   logic                               valid;
   logic                               ready;
   logic                               kind;
   logic signed [pcmf_pkg::COORD_W-1:0] point_x_mm;
   logic signed [pcmf_pkg::COORD_W-1:0] point_y_mm;
   logic signed [pcmf_pkg::COORD_W-1:0] point_z_mm;
   logic signed [pcmf_pkg::COORD_W-1:0] sensor_x_mm;
   logic signed [pcmf_pkg::COORD_W-1:0] sensor_y_mm;
   logic signed [pcmf_pkg::COORD_W-1:0] sensor_z_mm;

   modport source (output valid, kind, point_x_mm, point_y_mm, point_z_mm,
                   sensor_x_mm, sensor_y_mm, sensor_z_mm, input ready);
   modport sink   (input valid, kind, point_x_mm, point_y_mm, point_z_mm,
                   sensor_x_mm, sensor_y_mm, sensor_z_mm, output ready);
endinterface

interface pcmf_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [2:0]                         status;
   logic [9:0]                         cell_col;
   logic [9:0]                         cell_row;
   logic [19:0]                        cell_index;
   logic signed [pcmf_pkg::COORD_W-1:0] bound_min_x_mm;
   logic signed [pcmf_pkg::COORD_W-1:0] bound_min_y_mm;
   logic signed [pcmf_pkg::COORD_W-1:0] bound_max_x_mm;
   logic signed [pcmf_pkg::COORD_W-1:0] bound_max_y_mm;

   modport source (output valid, status, cell_col, cell_row, cell_index, bound_min_x_mm,
                   bound_min_y_mm, bound_max_x_mm, bound_max_y_mm, input ready);
   modport sink   (input valid, status, cell_col, cell_row, cell_index, bound_min_x_mm,
                   bound_min_y_mm, bound_max_x_mm, bound_max_y_mm, output ready);
endinterface

/* rtl/pcmf_front.sv */
// pcmf_front: three-stage classify pipeline (differences, products, range and map checks)
// depends on pcmf_pkg; feeds pcmf_queue
module pcmf_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  pcmf_pkg::item_type  in_item,
   input  pcmf_pkg::cfg_type   cfg,
   output logic                out_valid,
   output pcmf_pkg::entry_type out_entry
);

   localparam int CW = pcmf_pkg::COORD_W;
   localparam int MW = pcmf_pkg::MAG_W;

   // stage 1: differences and height checks
   logic                 s1_valid_ff;
   logic                 s1_kind_ff, s1_low_ff, s1_high_ff, s1_negx_ff, s1_negy_ff;
   logic [MW-1:0]        s1_dx_ff, s1_dy_ff, s1_dz_ff;
   logic [CW-1:0]        s1_mx_ff, s1_my_ff;
   logic signed [CW-1:0] s1_px_ff, s1_py_ff;

   logic signed [MW-1:0] dx_in, dy_in, dz_in, ox_in, oy_in;

   // stage 2: squares and reciprocal products
   logic                          s2_valid_ff;
   logic                          s2_kind_ff, s2_low_ff, s2_high_ff, s2_negx_ff, s2_negy_ff;
   logic [pcmf_pkg::SQ_W-1:0]     s2_sqx_ff, s2_sqy_ff, s2_sqz_ff;
   logic [pcmf_pkg::RSQ_W-1:0]    s2_max2_ff, s2_min2_ff;
   logic [pcmf_pkg::QUOT_W-1:0]   s2_qx_ff, s2_qy_ff;
   logic signed [CW-1:0]          s2_px_ff, s2_py_ff;

   // stage 3: classification
   logic                          s3_valid_ff;
   pcmf_pkg::entry_type           s3_entry_ff;
   pcmf_pkg::entry_type           s3_entry_in;
   logic [pcmf_pkg::DIST_W-1:0]   dist2_in;
   logic [CW-1:0]                 colw_in, roww_in;
   logic                          far_in, close_in, off_in;

   function automatic logic [MW-1:0] mag(input logic signed [MW-1:0] d);
      return d[MW-1] ? MW'(-d) : MW'(d);
   endfunction

   always_comb begin
      dx_in = MW'(in_item.point_x) - MW'(in_item.sensor_x);
      dy_in = MW'(in_item.point_y) - MW'(in_item.sensor_y);
      dz_in = MW'(in_item.point_z) - MW'(in_item.sensor_z);
      ox_in = MW'(in_item.point_x) - MW'(cfg.origin_x);
      oy_in = MW'(in_item.point_y) - MW'(cfg.origin_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_kind_ff <= in_item.kind;
      s1_low_ff  <= in_item.point_z < cfg.min_height;
      s1_high_ff <= in_item.point_z > cfg.max_height;
      s1_dx_ff   <= mag(dx_in);
      s1_dy_ff   <= mag(dy_in);
      s1_dz_ff   <= mag(dz_in);
      s1_negx_ff <= ox_in[MW-1];
      s1_negy_ff <= oy_in[MW-1];
      s1_mx_ff   <= ox_in[CW-1:0];
      s1_my_ff   <= oy_in[CW-1:0];
      s1_px_ff   <= in_item.point_x;
      s1_py_ff   <= in_item.point_y;
   end

   always_ff @(posedge clock) begin
      s2_kind_ff <= s1_kind_ff;
      s2_low_ff  <= s1_low_ff;
      s2_high_ff <= s1_high_ff;
      s2_negx_ff <= s1_negx_ff;
      s2_negy_ff <= s1_negy_ff;
      s2_sqx_ff  <= s1_dx_ff * s1_dx_ff;
      s2_sqy_ff  <= s1_dy_ff * s1_dy_ff;
      s2_sqz_ff  <= s1_dz_ff * s1_dz_ff;
      s2_max2_ff <= cfg.max_range * cfg.max_range;
      s2_min2_ff <= cfg.min_range * cfg.min_range;
      s2_qx_ff   <= s1_mx_ff * pcmf_pkg::RECIP;
      s2_qy_ff   <= s1_my_ff * pcmf_pkg::RECIP;
      s2_px_ff   <= s1_px_ff;
      s2_py_ff   <= s1_py_ff;
   end

   always_comb begin
      dist2_in = pcmf_pkg::DIST_W'(s2_sqx_ff) + pcmf_pkg::DIST_W'(s2_sqy_ff)
               + pcmf_pkg::DIST_W'(s2_sqz_ff);
      far_in   = dist2_in >= pcmf_pkg::DIST_W'(s2_max2_ff);
      close_in = dist2_in < pcmf_pkg::DIST_W'(s2_min2_ff);
      colw_in  = CW'(s2_qx_ff >> pcmf_pkg::DIV_SHIFT);
      roww_in  = CW'(s2_qy_ff >> pcmf_pkg::DIV_SHIFT);
      off_in   = s2_negx_ff || s2_negy_ff || (colw_in >= CW'(cfg.cells_x))
              || (roww_in >= CW'(cfg.cells_y));

      s3_entry_in.col = '0;
      s3_entry_in.row = '0;
      s3_entry_in.px  = s2_px_ff;
      s3_entry_in.py  = s2_py_ff;
      if (s2_kind_ff) begin
         s3_entry_in.status = pcmf_pkg::ST_CLEARED;
      end else if (s2_low_ff) begin
         s3_entry_in.status = pcmf_pkg::ST_LOW;
      end else if (s2_high_ff) begin
         s3_entry_in.status = pcmf_pkg::ST_HIGH;
      end else if (far_in) begin
         s3_entry_in.status = pcmf_pkg::ST_FAR;
      end else if (close_in) begin
         s3_entry_in.status = pcmf_pkg::ST_CLOSE;
      end else if (off_in) begin
         s3_entry_in.status = pcmf_pkg::ST_OFFMAP;
      end else begin
         s3_entry_in.status = pcmf_pkg::ST_MARKED;
         s3_entry_in.col    = colw_in[pcmf_pkg::IDX_W-1:0];
         s3_entry_in.row    = roww_in[pcmf_pkg::IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      s3_entry_ff <= s3_entry_in;
   end

   assign out_valid = s3_valid_ff;
   assign out_entry = s3_entry_ff;

endmodule

/* rtl/pcmf_queue.sv */
// pcmf_queue: small fifo of classified words between front and back
// depends on pcmf_pkg
module pcmf_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  pcmf_pkg::entry_type        push_entry,
   input  logic                       pop,
   output pcmf_pkg::entry_type        head_entry,
   output pcmf_pkg::queue_status_type status
);

   pcmf_pkg::entry_type               mem_ff [pcmf_pkg::QDEPTH];
   logic [pcmf_pkg::QPTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [pcmf_pkg::QCNT_W-1:0]       count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   assign head_entry       = mem_ff[rd_ptr_ff];
   assign status.not_empty = count_ff != '0;
   assign status.full      = count_ff == pcmf_pkg::QCNT_W'(pcmf_pkg::QDEPTH);

endmodule

/* rtl/pcmf_back.sv */
// pcmf_back: cell index, running bounds and response output register
// depends on pcmf_pkg and pcmf_rsp_if; drains pcmf_queue
module pcmf_back (
   input  logic                       clock,
   input  logic                       reset,
   input  pcmf_pkg::cfg_type          cfg,
   input  pcmf_pkg::queue_status_type q_status,
   input  pcmf_pkg::entry_type        head_entry,
   output logic                       pop,
   pcmf_rsp_if.source                 rsp
);

   localparam int CW  = pcmf_pkg::COORD_W;
   localparam int IXW = pcmf_pkg::IDX_W + pcmf_pkg::CNT_W;

   logic                 valid_ff;
   logic [2:0]           status_ff;
   logic [9:0]           col_ff, row_ff;
   logic [19:0]          index_ff;
   logic signed [CW-1:0] lo_x_ff, lo_y_ff, hi_x_ff, hi_y_ff;
   logic signed [CW-1:0] lo_x_in, lo_y_in, hi_x_in, hi_y_in;
   logic [IXW-1:0]       index_in;

   assign pop = q_status.not_empty && (!valid_ff || rsp.ready);

   always_comb begin
      index_in = IXW'(head_entry.row) * IXW'(cfg.cells_x) + IXW'(head_entry.col);
      lo_x_in  = lo_x_ff;
      lo_y_in  = lo_y_ff;
      hi_x_in  = hi_x_ff;
      hi_y_in  = hi_y_ff;
      case (head_entry.status)
         pcmf_pkg::ST_CLEARED: begin
            lo_x_in = pcmf_pkg::POS_MAX;
            lo_y_in = pcmf_pkg::POS_MAX;
            hi_x_in = pcmf_pkg::NEG_MAX;
            hi_y_in = pcmf_pkg::NEG_MAX;
         end
         pcmf_pkg::ST_MARKED: begin
            if (head_entry.px < lo_x_ff) lo_x_in = head_entry.px;
            if (head_entry.py < lo_y_ff) lo_y_in = head_entry.py;
            if (head_entry.px > hi_x_ff) hi_x_in = head_entry.px;
            if (head_entry.py > hi_y_ff) hi_y_in = head_entry.py;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         lo_x_ff  <= pcmf_pkg::POS_MAX;
         lo_y_ff  <= pcmf_pkg::POS_MAX;
         hi_x_ff  <= pcmf_pkg::NEG_MAX;
         hi_y_ff  <= pcmf_pkg::NEG_MAX;
      end else begin
         if (pop) begin
            valid_ff <= 1'b1;
            lo_x_ff  <= lo_x_in;
            lo_y_ff  <= lo_y_in;
            hi_x_ff  <= hi_x_in;
            hi_y_ff  <= hi_y_in;
         end else if (rsp.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff <= head_entry.status;
         col_ff    <= 10'(head_entry.col);
         row_ff    <= 10'(head_entry.row);
         index_ff  <= 20'(index_in);
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.status         = status_ff;
   assign rsp.cell_col       = col_ff;
   assign rsp.cell_row       = row_ff;
   assign rsp.cell_index     = index_ff;
   assign rsp.bound_min_x_mm = lo_x_ff;
   assign rsp.bound_min_y_mm = lo_y_ff;
   assign rsp.bound_max_x_mm = hi_x_ff;
   assign rsp.bound_max_y_mm = hi_y_ff;

endmodule

/* rtl/point_cloud_cell_marking_filter.sv */
// point_cloud_cell_marking_filter: top level with config registers and credit control
// depends on pcmf_pkg, pcmf_if, pcmf_front, pcmf_queue, pcmf_back
//
// usage:
// req carries one word per item: a 3d point with its sensor origin (kind 0) or a
// bounds clear command (kind 1). rsp returns exactly one word per request, in order:
// a status, the map cell of a marked point, and the running x/y bounds after it.
// csr_we writes register csr_index with csr_wdata; write only while the block is idle.
// a request passes the three front stages (differences, products, range and map checks),
// then a queue write, where it waits while the output register holds an untaken word,
// and then the output register, which raises response valid.
// throughput is one word per cycle while rsp.ready stays high; only the bounds compare and
// update in the back stage carries from word to word, and it is combinational into the bound registers.
// an 8-entry queue sits between the classify pipeline and the output stage; req.ready
// drops once 8 words are in flight or queued, so a stalled rsp.ready backs up into req
// after the queue fills while the output register keeps its word.
// reset is synchronous: the registers return to their defaults, the bounds go empty,
// the pipeline and queue are flushed; no clearing pass is needed.
module point_cloud_cell_marking_filter (
   input  logic                               clock,
   input  logic                               reset,
   pcmf_req_if.sink                           req,
   pcmf_rsp_if.source                         rsp,
   input  logic                               csr_we,
   input  logic [pcmf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pcmf_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int CW = pcmf_pkg::COORD_W;
   localparam int RW = pcmf_pkg::RANGE_W;

   logic signed [CW-1:0]               min_height_ff, max_height_ff, origin_x_ff, origin_y_ff;
   logic [RW-1:0]                      max_range_ff, min_range_ff;
   logic [pcmf_pkg::CELLS_REG_W-1:0]   cells_x_ff, cells_y_ff;
   logic [pcmf_pkg::QCNT_W-1:0]        credit_ff;

   pcmf_pkg::cfg_type                  cfg;
   pcmf_pkg::item_type                 item;
   pcmf_pkg::entry_type                front_entry, head_entry;
   pcmf_pkg::queue_status_type         q_status;
   logic                               accept, front_valid, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_height_ff <= -CW'(50);
         max_height_ff <= CW'(50);
         max_range_ff  <= RW'(2500);
         min_range_ff  <= '0;
         origin_x_ff   <= '0;
         origin_y_ff   <= '0;
         cells_x_ff    <= pcmf_pkg::CELLS_REG_W'(1024);
         cells_y_ff    <= pcmf_pkg::CELLS_REG_W'(1024);
      end else if (csr_we) begin
         case (csr_index)
            pcmf_pkg::REG_MIN_HEIGHT: min_height_ff <= csr_wdata;
            pcmf_pkg::REG_MAX_HEIGHT: max_height_ff <= csr_wdata;
            pcmf_pkg::REG_MAX_RANGE:  max_range_ff  <= csr_wdata[RW-1:0];
            pcmf_pkg::REG_MIN_RANGE:  min_range_ff  <= csr_wdata[RW-1:0];
            pcmf_pkg::REG_ORIGIN_X:   origin_x_ff   <= csr_wdata;
            pcmf_pkg::REG_ORIGIN_Y:   origin_y_ff   <= csr_wdata;
            pcmf_pkg::REG_CELLS_X:    cells_x_ff    <= csr_wdata[pcmf_pkg::CELLS_REG_W-1:0];
            pcmf_pkg::REG_CELLS_Y:    cells_y_ff    <= csr_wdata[pcmf_pkg::CELLS_REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.min_height = min_height_ff;
      cfg.max_height = max_height_ff;
      cfg.max_range  = max_range_ff;
      cfg.min_range  = min_range_ff;
      cfg.origin_x   = origin_x_ff;
      cfg.origin_y   = origin_y_ff;
      cfg.cells_x    = pcmf_pkg::sat_cells(cells_x_ff);
      cfg.cells_y    = pcmf_pkg::sat_cells(cells_y_ff);

      item.kind     = req.kind;
      item.point_x  = req.point_x_mm;
      item.point_y  = req.point_y_mm;
      item.point_z  = req.point_z_mm;
      item.sensor_x = req.sensor_x_mm;
      item.sensor_y = req.sensor_y_mm;
      item.sensor_z = req.sensor_z_mm;
   end

   // words in the front pipeline plus words in the queue
   assign req.ready = credit_ff < pcmf_pkg::QCNT_W'(pcmf_pkg::QDEPTH);
   assign accept    = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         case ({accept, pop})
            2'b10:   credit_ff <= credit_ff + 1'b1;
            2'b01:   credit_ff <= credit_ff - 1'b1;
            default: credit_ff <= credit_ff;
         endcase
      end
   end

   pcmf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_item   (item),
      .cfg       (cfg),
      .out_valid (front_valid),
      .out_entry (front_entry)
   );

   pcmf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_valid),
      .push_entry (front_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   pcmf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_status   (q_status),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp        (rsp)
   );

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= pcmf_pkg::QCNT_W'(pcmf_pkg::QDEPTH))
      else $error("credit count above queue depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (front_valid && q_status.full) |-> pop)
      else $error("queue written while full");

   a_unmarked_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status != pcmf_pkg::ST_MARKED) |->
      (rsp.cell_col == '0 && rsp.cell_row == '0 && rsp.cell_index == '0))
      else $error("cell fields set on an unmarked word");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> (!rsp.valid && credit_ff == '0))
      else $error("response valid right after reset");

endmodule

/* bench/tb_point_cloud_cell_marking_filter.sv */
// tb_point_cloud_cell_marking_filter: self-checking bench that streams points and bounds clears
// through the filter under random idling and compares every response word with its own predictor
// depends on pcmf_pkg, pcmf_if and the point_cloud_cell_marking_filter rtl
module tb_point_cloud_cell_marking_filter;
   timeunit 1ns;
   timeprecision 1ps;

   import pcmf_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 10;
   localparam logic [RANGE_W-1:0] RANGE_TOP = {RANGE_W{1'b1}};

   typedef struct packed {
      status_type                status;
      logic [IDX_W-1:0]          col;
      logic [IDX_W-1:0]          row;
      logic [2*IDX_W-1:0]        flat;
      logic signed [COORD_W-1:0] lo_x;
      logic signed [COORD_W-1:0] lo_y;
      logic signed [COORD_W-1:0] hi_x;
      logic signed [COORD_W-1:0] hi_y;
   } verdict_type;

   logic clock = 1'b0;
   logic reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   pcmf_req_if req_ch ();
   pcmf_rsp_if rsp_ch ();

   point_cloud_cell_marking_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // register copies used by the predictor
   logic signed [COORD_W-1:0] cfg_min_h   = -50;
   logic signed [COORD_W-1:0] cfg_max_h   = 50;
   logic [RANGE_W-1:0]        cfg_far     = 2500;
   logic [RANGE_W-1:0]        cfg_near    = 0;
   logic signed [COORD_W-1:0] cfg_org_x   = 0;
   logic signed [COORD_W-1:0] cfg_org_y   = 0;
   logic [CELLS_REG_W-1:0]    cfg_cells_x = 1024;
   logic [CELLS_REG_W-1:0]    cfg_cells_y = 1024;

   // running world bounds of marked points
   logic signed [COORD_W-1:0] lo_x = POS_MAX;
   logic signed [COORD_W-1:0] lo_y = POS_MAX;
   logic signed [COORD_W-1:0] hi_x = NEG_MAX;
   logic signed [COORD_W-1:0] hi_y = NEG_MAX;

   item_type    pending_words[$];
   verdict_type verdicts_due[$];
   item_type    on_wire;
   int unsigned words_queued = 0;
   int unsigned words_taken = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int          src_wait = 0;
   int          snk_wait = 0;
   bit          src_steady = 1'b0;
   bit          snk_steady = 1'b0;

   function automatic longint cells_in_use(input logic [CELLS_REG_W-1:0] n);
      return (n > MAX_CELLS_PER_AXIS) ? longint'(MAX_CELLS_PER_AXIS) : longint'(n);
   endfunction

   function automatic verdict_type mark_point(input item_type w);
      verdict_type v;
      longint dx, dy, dz, ox, oy, ncx, ncy, qc, qr;
      longint unsigned dist2, far2, near2;
      v = '0;
      if (w.kind) begin
         lo_x = POS_MAX;
         lo_y = POS_MAX;
         hi_x = NEG_MAX;
         hi_y = NEG_MAX;
         v.status = ST_CLEARED;
      end else begin
         dx = longint'(w.point_x) - longint'(w.sensor_x);
         dy = longint'(w.point_y) - longint'(w.sensor_y);
         dz = longint'(w.point_z) - longint'(w.sensor_z);
         dist2 = dx * dx + dy * dy + dz * dz;
         far2 = longint'(cfg_far) * longint'(cfg_far);
         near2 = longint'(cfg_near) * longint'(cfg_near);
         ox = longint'(w.point_x) - longint'(cfg_org_x);
         oy = longint'(w.point_y) - longint'(cfg_org_y);
         ncx = cells_in_use(cfg_cells_x);
         ncy = cells_in_use(cfg_cells_y);
         qc = ox / CELL_SIZE_MM;
         qr = oy / CELL_SIZE_MM;
         if (w.point_z < cfg_min_h) begin
            v.status = ST_LOW;
         end else if (w.point_z > cfg_max_h) begin
            v.status = ST_HIGH;
         end else if (dist2 >= far2) begin
            v.status = ST_FAR;
         end else if (dist2 < near2) begin
            v.status = ST_CLOSE;
         end else if (ox < 0 || oy < 0 || qc >= ncx || qr >= ncy) begin
            v.status = ST_OFFMAP;
         end else begin
            v.status = ST_MARKED;
            v.col = IDX_W'(qc);
            v.row = IDX_W'(qr);
            v.flat = (2*IDX_W)'(qr * ncx + qc);
            if (w.point_x < lo_x) lo_x = w.point_x;
            if (w.point_y < lo_y) lo_y = w.point_y;
            if (w.point_x > hi_x) hi_x = w.point_x;
            if (w.point_y > hi_y) hi_y = w.point_y;
         end
      end
      v.lo_x = lo_x;
      v.lo_y = lo_y;
      v.hi_x = hi_x;
      v.hi_y = hi_y;
      return v;
   endfunction

   function automatic logic signed [COORD_W-1:0] clamp24(input longint v);
      if (v > longint'(POS_MAX)) return POS_MAX;
      if (v < longint'(NEG_MAX)) return NEG_MAX;
      return COORD_W'(v);
   endfunction

   function automatic logic signed [COORD_W-1:0] wild24();
      case ($urandom_range(0, 7))
         0: return NEG_MAX;
         1: return POS_MAX;
         2: return '0;
         default: return COORD_W'($urandom());
      endcase
   endfunction

   function automatic item_type pt(input longint x, input longint y, input longint z,
                                   input longint sx, input longint sy, input longint sz);
      item_type w;
      w.kind = 1'b0;
      w.point_x = clamp24(x);
      w.point_y = clamp24(y);
      w.point_z = clamp24(z);
      w.sensor_x = clamp24(sx);
      w.sensor_y = clamp24(sy);
      w.sensor_z = clamp24(sz);
      return w;
   endfunction

   function automatic item_type wild_point(input logic kind);
      item_type w;
      w.kind = kind;
      w.point_x = wild24();
      w.point_y = wild24();
      w.point_z = wild24();
      w.sensor_x = wild24();
      w.sensor_y = wild24();
      w.sensor_z = wild24();
      return w;
   endfunction

   // mostly in band, in range and on the current map, with some spill over each edge
   function automatic item_type aimed_point();
      item_type w;
      longint lo, hi, reach, span_x, span_y;
      span_x = cells_in_use(cfg_cells_x) * CELL_SIZE_MM;
      span_y = cells_in_use(cfg_cells_y) * CELL_SIZE_MM;
      lo = cfg_min_h;
      hi = cfg_max_h;
      if (hi < lo) begin
         lo = cfg_max_h;
         hi = cfg_min_h;
      end
      reach = longint'(cfg_far) * $urandom_range(1, 8) / 10 + 1;
      w.kind = 1'b0;
      w.point_x = clamp24(cfg_org_x + longint'($urandom_range(0, int'(span_x) + 80)) - 40);
      w.point_y = clamp24(cfg_org_y + longint'($urandom_range(0, int'(span_y) + 80)) - 40);
      w.point_z = clamp24(lo - 2 + longint'($urandom_range(0, int'(hi - lo) + 4)));
      w.sensor_x = clamp24(w.point_x - reach + longint'($urandom_range(0, int'(2 * reach))));
      w.sensor_y = clamp24(w.point_y - reach + longint'($urandom_range(0, int'(2 * reach))));
      w.sensor_z = clamp24(w.point_z - reach + longint'($urandom_range(0, int'(2 * reach))));
      return w;
   endfunction

   task automatic queue_word(input item_type w);
      pending_words = {pending_words, w};
      words_queued++;
   endtask

   task automatic run_phase(input int count);
      item_type w;
      longint gap[4];
      gap = '{longint'(cfg_far), longint'(cfg_far) - 1, longint'(cfg_near),
              longint'(cfg_near) - 1};
      // distances right on the range limits
      foreach (gap[k]) begin
         w = aimed_point();
         w.sensor_x = clamp24(longint'(w.point_x) - gap[k]);
         w.sensor_y = w.point_y;
         w.sensor_z = w.point_z;
         queue_word(w);
      end
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 15))
            0: w = wild_point(1'b1);
            1, 2, 3: w = wild_point(1'b0);
            default: w = aimed_point();
         endcase
         queue_word(w);
      end
   endtask

   task automatic drain();
      while (words_taken != words_queued || verdicts_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_reg(input csr_reg_type r, input logic [CSR_W-1:0] v);
      csr_we <= 1'b1;
      csr_index <= r;
      csr_wdata <= v;
      @(posedge clock);
   endtask

   task automatic set_regs(input logic signed [COORD_W-1:0] min_h,
                           input logic signed [COORD_W-1:0] max_h,
                           input logic [RANGE_W-1:0] far, input logic [RANGE_W-1:0] near,
                           input logic signed [COORD_W-1:0] org_x,
                           input logic signed [COORD_W-1:0] org_y,
                           input logic [CELLS_REG_W-1:0] cells_x,
                           input logic [CELLS_REG_W-1:0] cells_y);
      cfg_min_h = min_h;
      cfg_max_h = max_h;
      cfg_far = far;
      cfg_near = near;
      cfg_org_x = org_x;
      cfg_org_y = org_y;
      cfg_cells_x = cells_x;
      cfg_cells_y = cells_y;
      put_reg(REG_MIN_HEIGHT, min_h);
      put_reg(REG_MAX_HEIGHT, max_h);
      put_reg(REG_MAX_RANGE, CSR_W'(far));
      put_reg(REG_MIN_RANGE, CSR_W'(near));
      put_reg(REG_ORIGIN_X, org_x);
      put_reg(REG_ORIGIN_Y, org_y);
      put_reg(REG_CELLS_X, CSR_W'(cells_x));
      put_reg(REG_CELLS_Y, CSR_W'(cells_y));
      csr_we <= 1'b0;
   endtask

   task automatic random_regs();
      logic [RANGE_W-1:0] far;
      logic signed [COORD_W-1:0] org_x, org_y;
      far = RANGE_W'($urandom_range(100, 20000));
      org_x = ($urandom_range(0, 3) == 0) ? wild24() :
              COORD_W'(longint'($urandom_range(0, 40000)) - 20000);
      org_y = ($urandom_range(0, 3) == 0) ? wild24() :
              COORD_W'(longint'($urandom_range(0, 40000)) - 20000);
      set_regs(COORD_W'(-longint'($urandom_range(0, 3000))), COORD_W'($urandom_range(0, 3000)),
               far, RANGE_W'($urandom_range(0, int'(far) / 2)), org_x, org_y,
               CELLS_REG_W'($urandom_range(1, 1100)), CELLS_REG_W'($urandom_range(1, 1100)));
   endtask

   task automatic check_field(input string what, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         src_wait = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            verdicts_due = {verdicts_due, mark_point(on_wire)};
            words_taken++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (src_wait > 0) begin
               req_ch.valid <= 1'b0;
               src_wait--;
            end else if (pending_words.size() > 0) begin
               on_wire = pending_words.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.kind <= on_wire.kind;
               req_ch.point_x_mm <= on_wire.point_x;
               req_ch.point_y_mm <= on_wire.point_y;
               req_ch.point_z_mm <= on_wire.point_z;
               req_ch.sensor_x_mm <= on_wire.sensor_x;
               req_ch.sensor_y_mm <= on_wire.sensor_y;
               req_ch.sensor_z_mm <= on_wire.sensor_z;
               if ($urandom_range(0, 63) == 0) src_steady = !src_steady;
               src_wait = src_steady ? 0 : $urandom_range(0, 4);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         snk_wait = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (verdicts_due.size() == 0) begin
               $display("%0t: response word with nothing due, status %0d", $time,
                        rsp_ch.status);
               mismatch_count++;
            end else begin
               want = verdicts_due.pop_front();
               check_field("status", want.status, rsp_ch.status);
               check_field("cell_col", want.col, rsp_ch.cell_col);
               check_field("cell_row", want.row, rsp_ch.cell_row);
               check_field("cell_index", want.flat, rsp_ch.cell_index);
               check_field("bound_min_x_mm", want.lo_x, rsp_ch.bound_min_x_mm);
               check_field("bound_min_y_mm", want.lo_y, rsp_ch.bound_min_y_mm);
               check_field("bound_max_x_mm", want.hi_x, rsp_ch.bound_max_x_mm);
               check_field("bound_max_y_mm", want.hi_y, rsp_ch.bound_max_y_mm);
            end
            if ($urandom_range(0, 63) == 0) snk_steady = !snk_steady;
            snk_wait = snk_steady ? 0 : $urandom_range(0, 4);
         end
         if (snk_wait > 0) begin
            rsp_ch.ready <= 1'b0;
            snk_wait--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL point_cloud_cell_marking_filter");
      $finish;
   end

   initial begin
      item_type w;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = REG_MIN_HEIGHT;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.kind = 1'b0;
      req_ch.point_x_mm = '0;
      req_ch.point_y_mm = '0;
      req_ch.point_z_mm = '0;
      req_ch.sensor_x_mm = '0;
      req_ch.sensor_y_mm = '0;
      req_ch.sensor_z_mm = '0;
      rsp_ch.ready = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // default registers: band edges, range edge, map edges, field extremes, clears
      queue_word(pt(0, 0, 0, 0, 0, 0));
      queue_word(pt(49, 50, -50, 49, 50, 0));
      queue_word(pt(10, 10, -51, 10, 10, 0));
      queue_word(pt(10, 10, 51, 10, 10, 0));
      queue_word(pt(10, 10, 50, 10, 10, 0));
      queue_word(pt(0, 0, NEG_MAX, 0, 0, 0));
      queue_word(pt(0, 0, POS_MAX, 0, 0, 0));
      queue_word(pt(100, 100, 0, 2600, 100, 0));
      queue_word(pt(100, 100, 0, 2599, 100, 0));
      queue_word(pt(-1, 10, 0, -1, 10, 0));
      queue_word(pt(10, -1, 0, 10, -1, 0));
      queue_word(pt(51199, 51199, 0, 51199, 51199, 0));
      queue_word(pt(51200, 0, 0, 51200, 0, 0));
      queue_word(pt(0, 51200, 0, 0, 51200, 0));
      queue_word(pt(POS_MAX, POS_MAX, 0, POS_MAX, POS_MAX, 0));
      queue_word(pt(NEG_MAX, NEG_MAX, 0, NEG_MAX, NEG_MAX, 0));
      queue_word(pt(0, 0, 0, NEG_MAX, NEG_MAX, NEG_MAX));
      queue_word(pt(0, 0, 0, POS_MAX, POS_MAX, POS_MAX));
      queue_word(wild_point(1'b1));
      w = '1;
      queue_word(w);
      queue_word(pt(777, 333, -3, 0, 0, 0));
      queue_word(pt(1500, 20, 5, 1000, 500, 0));
      run_phase(280);
      drain();

      set_regs(NEG_MAX, POS_MAX, RANGE_TOP, '0, NEG_MAX, NEG_MAX, 1024, 1024);
      run_phase(250);
      drain();

      // zero columns, oversized row count
      set_regs(-300, 300, 2000, 300, 5000, -7000, 0, 2047);
      run_phase(160);
      drain();

      // minimum range above maximum range
      set_regs(-1000, 1000, 1000, 3000, -500, -500, 2047, 1);
      run_phase(150);
      drain();

      set_regs(7, 7, '0, RANGE_TOP, POS_MAX, NEG_MAX, 1, 1);
      run_phase(60);
      drain();

      set_regs('0, '0, 1, '0, '0, '0, 1, 1);
      run_phase(60);
      drain();

      repeat (6) begin
         random_regs();
         run_phase(130);
         drain();
      end

      if (mismatch_count == 0)
         $display("PASS point_cloud_cell_marking_filter");
      else
         $display("FAIL point_cloud_cell_marking_filter");
      $finish;
   end

endmodule

/* sim.f */
rtl/pcmf_pkg.sv
rtl/pcmf_if.sv
rtl/pcmf_front.sv
rtl/pcmf_queue.sv
rtl/pcmf_back.sv
rtl/point_cloud_cell_marking_filter.sv
bench/tb_point_cloud_cell_marking_filter.sv
